// File: rtl/core/sle_pkg.sv
package sle_pkg;

  // Default list depth
  localparam int unsigned CAPACITY = 128;

  // Command codes
  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_GET     = 3'd1;
  localparam logic [2:0] CMD_LOCATE  = 3'd2;
  localparam logic [2:0] CMD_INSERT  = 3'd3;
  localparam logic [2:0] CMD_DELETE  = 3'd4;
  localparam logic [2:0] CMD_REVERSE = 3'd5;

  // Input word
  typedef struct packed {
    logic [2:0]         command;
    logic [7:0]         position;
    logic signed [31:0] value_in;
  } sle_in_word_t;

  // Result word
  typedef struct packed {
    logic               status;
    logic signed [31:0] value_out;
    logic [7:0]         found_position;
    logic [7:0]         count_out;
  } sle_out_word_t;

  // Walk pointer update
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_COUNT,
    PTR_POS,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  // Upper pointer update (reverse)
  typedef enum logic [1:0] {
    HI_HOLD,
    HI_TOP,
    HI_DEC
  } hi_op_e;

  // Store address select, shared by read and write ports
  typedef enum logic [1:0] {
    ADR_PTR,
    ADR_PTR_M1,
    ADR_HI,
    ADR_POS_M1
  } adr_sel_e;

  // Store write data select
  typedef enum logic [1:0] {
    WD_RDATA,
    WD_VAL,
    WD_HOLD
  } wd_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     set_err;
    logic     cnt_clear;
    logic     cnt_inc;
    logic     cnt_dec;
    ptr_op_e  ptr_op;
    hi_op_e   hi_op;
    logic     rd_en;
    adr_sel_e rd_sel;
    logic     wr_en;
    adr_sel_e wr_sel;
    wd_sel_e  wd_sel;
    logic     hold_ld;
    logic     vout_ld;
    logic     found_ld;
    logic     out_ld;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] command;
    logic       get_ok;
    logic       ins_ok;
    logic       del_ok;
    logic       rev_ok;
    logic       ptr_lt_cnt;
    logic       ptr_ge_pos;
    logic       ptr_lt_hi;
    logic       match;
    logic       out_free;
  } dp_stat_t;

endpackage

// File: rtl/core/sle_word_if.sv
interface sle_word_if #(
  parameter type word_t = logic
);

  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);

endinterface

// File: rtl/core/sle_datapath.sv
module sle_datapath #(
  parameter int unsigned CAPACITY = sle_pkg::CAPACITY
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sle_pkg::sle_in_word_t in_word_i,
  input  sle_pkg::dp_cmd_t      dp_cmd_i,
  output sle_pkg::dp_stat_t     dp_stat_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sle_pkg::sle_out_word_t out_word_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned PW = ((CW > 8) ? CW : 8) + 1;

  // Latched word
  logic [2:0]  cmd_q;
  logic [7:0]  pos_q;
  logic [31:0] val_q;

  // Walk state
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] hi_q, hi_d;

  // Store and its read register
  logic [31:0] store_mem [CAPACITY];
  logic [31:0] rdata_q;
  logic [31:0] hold_q;

  // Working result and output register
  logic        res_status_q;
  logic [31:0] res_vout_q;
  logic [7:0]  res_found_q;
  logic        out_valid_q;
  sle_pkg::sle_out_word_t out_word_q;

  logic [PW-1:0] pos_ext, cnt_ext, ptr_ext, found_ext;
  logic [CW-1:0] ptr_m1;
  logic [PW-1:0] pos_m1;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   wr_data;

  assign pos_ext   = PW'(pos_q);
  assign cnt_ext   = PW'(count_q);
  assign ptr_ext   = PW'(ptr_q);
  assign found_ext = ptr_ext + PW'(1);
  assign ptr_m1    = ptr_q - CW'(1);
  assign pos_m1    = pos_ext - PW'(1);

  // Address select for one port
  function automatic logic [AW-1:0] sel_addr(
    input sle_pkg::adr_sel_e sel,
    input logic [CW-1:0]     ptr,
    input logic [CW-1:0]     ptr_dec,
    input logic [CW-1:0]     hi,
    input logic [PW-1:0]     pos_dec
  );
    logic [AW-1:0] addr;
    case (sel)
      sle_pkg::ADR_PTR:    addr = ptr[AW-1:0];
      sle_pkg::ADR_PTR_M1: addr = ptr_dec[AW-1:0];
      sle_pkg::ADR_HI:     addr = hi[AW-1:0];
      sle_pkg::ADR_POS_M1: addr = pos_dec[AW-1:0];
      default:             addr = ptr[AW-1:0];
    endcase
    return addr;
  endfunction

  assign rd_addr = sel_addr(dp_cmd_i.rd_sel, ptr_q, ptr_m1, hi_q, pos_m1);
  assign wr_addr = sel_addr(dp_cmd_i.wr_sel, ptr_q, ptr_m1, hi_q, pos_m1);

  // Write data select
  always_comb begin
    case (dp_cmd_i.wd_sel)
      sle_pkg::WD_RDATA: wr_data = rdata_q;
      sle_pkg::WD_VAL:   wr_data = val_q;
      sle_pkg::WD_HOLD:  wr_data = hold_q;
      default:           wr_data = rdata_q;
    endcase
  end

  // Count and pointer updates
  always_comb begin
    count_d = count_q;
    if (dp_cmd_i.cnt_clear) begin
      count_d = '0;
    end else if (dp_cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (dp_cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end

    case (dp_cmd_i.ptr_op)
      sle_pkg::PTR_HOLD:  ptr_d = ptr_q;
      sle_pkg::PTR_ZERO:  ptr_d = '0;
      sle_pkg::PTR_COUNT: ptr_d = count_q;
      sle_pkg::PTR_POS:   ptr_d = pos_ext[CW-1:0];
      sle_pkg::PTR_INC:   ptr_d = ptr_q + CW'(1);
      sle_pkg::PTR_DEC:   ptr_d = ptr_m1;
      default:            ptr_d = ptr_q;
    endcase

    case (dp_cmd_i.hi_op)
      sle_pkg::HI_HOLD: hi_d = hi_q;
      sle_pkg::HI_TOP:  hi_d = count_q - CW'(1);
      sle_pkg::HI_DEC:  hi_d = hi_q - CW'(1);
      default:          hi_d = hi_q;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      hi_q    <= hi_d;
      if (dp_cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Store, read register and payload registers
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (dp_cmd_i.rd_en) begin
      rdata_q <= store_mem[rd_addr];
    end
    if (dp_cmd_i.hold_ld) begin
      hold_q <= rdata_q;
    end
    if (dp_cmd_i.load) begin
      cmd_q        <= in_word_i.command;
      pos_q        <= in_word_i.position;
      val_q        <= in_word_i.value_in;
      res_status_q <= 1'b0;
      res_vout_q   <= '0;
      res_found_q  <= '0;
    end else begin
      if (dp_cmd_i.set_err) begin
        res_status_q <= 1'b1;
      end
      if (dp_cmd_i.vout_ld) begin
        res_vout_q <= rdata_q;
      end
      if (dp_cmd_i.found_ld) begin
        res_found_q <= found_ext[7:0];
      end
    end
    if (dp_cmd_i.out_ld) begin
      out_word_q.status         <= res_status_q;
      out_word_q.value_out      <= res_vout_q;
      out_word_q.found_position <= res_found_q;
      out_word_q.count_out      <= cnt_ext[7:0];
    end
  end

  // Status to controller
  assign dp_stat_o.command    = cmd_q;
  assign dp_stat_o.get_ok     = (pos_q != 8'd0) && (pos_ext <= cnt_ext);
  assign dp_stat_o.ins_ok     = (pos_q != 8'd0) && (pos_ext <= cnt_ext + PW'(1))
                                && (cnt_ext < PW'(CAPACITY));
  assign dp_stat_o.del_ok     = (pos_q != 8'd0) && (pos_ext <= cnt_ext);
  assign dp_stat_o.rev_ok     = cnt_ext > PW'(1);
  assign dp_stat_o.ptr_lt_cnt = ptr_q < count_q;
  assign dp_stat_o.ptr_ge_pos = ptr_ext >= pos_ext;
  assign dp_stat_o.ptr_lt_hi  = ptr_q < hi_q;
  assign dp_stat_o.match      = rdata_q == val_q;
  assign dp_stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// File: rtl/core/sle_controller.sv
module sle_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sle_pkg::dp_stat_t dp_stat_i,
  output sle_pkg::dp_cmd_t  dp_cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_GET_WAIT = 4'd2;
  localparam logic [3:0] S_LOC_CHK  = 4'd3;
  localparam logic [3:0] S_LOC_CMP  = 4'd4;
  localparam logic [3:0] S_INS_CHK  = 4'd5;
  localparam logic [3:0] S_INS_WR   = 4'd6;
  localparam logic [3:0] S_DEL_CHK  = 4'd7;
  localparam logic [3:0] S_DEL_WR   = 4'd8;
  localparam logic [3:0] S_REV_CHK  = 4'd9;
  localparam logic [3:0] S_REV_RDHI = 4'd10;
  localparam logic [3:0] S_REV_WLO  = 4'd11;
  localparam logic [3:0] S_REV_WHI  = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  logic [3:0] state_q, state_d;

  assign in_ready_o = state_q == S_IDLE;

  // Next state and datapath commands
  always_comb begin
    state_d  = state_q;
    dp_cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          dp_cmd_o.load = 1'b1;
          state_d       = S_DECODE;
        end
      end

      S_DECODE: begin
        state_d = S_DONE;
        case (dp_stat_i.command)
          sle_pkg::CMD_CLEAR: begin
            dp_cmd_o.cnt_clear = 1'b1;
          end
          sle_pkg::CMD_GET: begin
            if (dp_stat_i.get_ok) begin
              dp_cmd_o.rd_en  = 1'b1;
              dp_cmd_o.rd_sel = sle_pkg::ADR_POS_M1;
              state_d         = S_GET_WAIT;
            end else begin
              dp_cmd_o.set_err = 1'b1;
            end
          end
          sle_pkg::CMD_LOCATE: begin
            dp_cmd_o.ptr_op = sle_pkg::PTR_ZERO;
            state_d         = S_LOC_CHK;
          end
          sle_pkg::CMD_INSERT: begin
            if (dp_stat_i.ins_ok) begin
              dp_cmd_o.ptr_op = sle_pkg::PTR_COUNT;
              state_d         = S_INS_CHK;
            end else begin
              dp_cmd_o.set_err = 1'b1;
            end
          end
          sle_pkg::CMD_DELETE: begin
            if (dp_stat_i.del_ok) begin
              dp_cmd_o.ptr_op = sle_pkg::PTR_POS;
              state_d         = S_DEL_CHK;
            end else begin
              dp_cmd_o.set_err = 1'b1;
            end
          end
          sle_pkg::CMD_REVERSE: begin
            if (dp_stat_i.rev_ok) begin
              dp_cmd_o.ptr_op = sle_pkg::PTR_ZERO;
              dp_cmd_o.hi_op  = sle_pkg::HI_TOP;
              state_d         = S_REV_CHK;
            end
          end
          default: begin
            dp_cmd_o.set_err = 1'b1;
          end
        endcase
      end

      S_GET_WAIT: begin
        dp_cmd_o.vout_ld = 1'b1;
        state_d          = S_DONE;
      end

      // Locate: read one entry, compare it the next cycle
      S_LOC_CHK: begin
        if (dp_stat_i.ptr_lt_cnt) begin
          dp_cmd_o.rd_en  = 1'b1;
          dp_cmd_o.rd_sel = sle_pkg::ADR_PTR;
          state_d         = S_LOC_CMP;
        end else begin
          state_d = S_DONE;
        end
      end

      S_LOC_CMP: begin
        if (dp_stat_i.match) begin
          dp_cmd_o.found_ld = 1'b1;
          state_d           = S_DONE;
        end else begin
          dp_cmd_o.ptr_op = sle_pkg::PTR_INC;
          state_d         = S_LOC_CHK;
        end
      end

      // Insert: move entries up from the top, then drop the value in
      S_INS_CHK: begin
        if (dp_stat_i.ptr_ge_pos) begin
          dp_cmd_o.rd_en  = 1'b1;
          dp_cmd_o.rd_sel = sle_pkg::ADR_PTR_M1;
          state_d         = S_INS_WR;
        end else begin
          dp_cmd_o.wr_en   = 1'b1;
          dp_cmd_o.wr_sel  = sle_pkg::ADR_POS_M1;
          dp_cmd_o.wd_sel  = sle_pkg::WD_VAL;
          dp_cmd_o.cnt_inc = 1'b1;
          state_d          = S_DONE;
        end
      end

      S_INS_WR: begin
        dp_cmd_o.wr_en  = 1'b1;
        dp_cmd_o.wr_sel = sle_pkg::ADR_PTR;
        dp_cmd_o.wd_sel = sle_pkg::WD_RDATA;
        dp_cmd_o.ptr_op = sle_pkg::PTR_DEC;
        state_d         = S_INS_CHK;
      end

      // Delete: move later entries down one place
      S_DEL_CHK: begin
        if (dp_stat_i.ptr_lt_cnt) begin
          dp_cmd_o.rd_en  = 1'b1;
          dp_cmd_o.rd_sel = sle_pkg::ADR_PTR;
          state_d         = S_DEL_WR;
        end else begin
          dp_cmd_o.cnt_dec = 1'b1;
          state_d          = S_DONE;
        end
      end

      S_DEL_WR: begin
        dp_cmd_o.wr_en  = 1'b1;
        dp_cmd_o.wr_sel = sle_pkg::ADR_PTR_M1;
        dp_cmd_o.wd_sel = sle_pkg::WD_RDATA;
        dp_cmd_o.ptr_op = sle_pkg::PTR_INC;
        state_d         = S_DEL_CHK;
      end

      // Reverse: swap the low and high entries, walk inward
      S_REV_CHK: begin
        if (dp_stat_i.ptr_lt_hi) begin
          dp_cmd_o.rd_en  = 1'b1;
          dp_cmd_o.rd_sel = sle_pkg::ADR_PTR;
          state_d         = S_REV_RDHI;
        end else begin
          state_d = S_DONE;
        end
      end

      S_REV_RDHI: begin
        dp_cmd_o.rd_en   = 1'b1;
        dp_cmd_o.rd_sel  = sle_pkg::ADR_HI;
        dp_cmd_o.hold_ld = 1'b1;
        state_d          = S_REV_WLO;
      end

      S_REV_WLO: begin
        dp_cmd_o.wr_en  = 1'b1;
        dp_cmd_o.wr_sel = sle_pkg::ADR_PTR;
        dp_cmd_o.wd_sel = sle_pkg::WD_RDATA;
        state_d         = S_REV_WHI;
      end

      S_REV_WHI: begin
        dp_cmd_o.wr_en  = 1'b1;
        dp_cmd_o.wr_sel = sle_pkg::ADR_HI;
        dp_cmd_o.wd_sel = sle_pkg::WD_HOLD;
        dp_cmd_o.ptr_op = sle_pkg::PTR_INC;
        dp_cmd_o.hi_op  = sle_pkg::HI_DEC;
        state_d         = S_REV_CHK;
      end

      // Hand the result word to the output register once it is free
      S_DONE: begin
        if (dp_stat_i.out_free) begin
          dp_cmd_o.out_ld = 1'b1;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/sequential_list_engine.sv
// Ordered list of signed 32-bit values in a single-port-per-direction store.
// cmd_i carries one command word (command, position, value_in); res_o returns
// one result word (status, value_out, found_position, count_out) per command.
// A command word is taken only while the engine is idle; the next one can be
// taken while the previous result still waits in the output register.
// A command passes from acceptance through decode, the store reads and writes
// that it needs, and the result load; the next word can be accepted in the
// cycle after the result is loaded.
// The walk moves one entry per read plus write, and one swapped pair per two
// reads and two writes, bounded by the store's one read and one write port.
// Reset empties the list (entry count zero); the store keeps no reset value.
// When the receiver stalls, the finished result holds in the output register
// and the engine waits before loading the next result into it.
module sequential_list_engine #(
  parameter int unsigned CAPACITY = sle_pkg::CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sle_word_if.sink   cmd_i,
  sle_word_if.source res_o
);

  sle_pkg::dp_cmd_t      dp_cmd;
  sle_pkg::dp_stat_t     dp_stat;
  sle_pkg::sle_in_word_t in_word;
  sle_pkg::sle_out_word_t out_word;
  logic                  in_ready;
  logic                  in_accept;
  logic                  out_valid;

  assign in_word     = cmd_i.word;
  assign cmd_i.ready = in_ready;
  assign in_accept   = cmd_i.valid && in_ready;
  assign res_o.valid = out_valid;
  assign res_o.word  = out_word;

  sle_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_accept),
    .in_ready_o (in_ready),
    .dp_stat_i  (dp_stat),
    .dp_cmd_o   (dp_cmd)
  );

  sle_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word),
    .dp_cmd_i    (dp_cmd),
    .dp_stat_o   (dp_stat),
    .out_valid_o (out_valid),
    .out_ready_i (res_o.ready),
    .out_word_o  (out_word)
  );

endmodule
